FILE: rtl/usd_pkg.sv
package usd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [20:0] REPL_CP  = 21'h00FFFD;
    localparam logic [20:0] MAX_CP   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO  = 21'h00D800;
    localparam logic [20:0] SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] MIN_CP4  = 21'h010000;
    localparam logic [20:0] MIN_CP3  = 21'h000800;
    localparam logic [20:0] MIN_CP2  = 21'h000080;
    localparam logic [7:0]  CONT_MSK = 8'hC0;
    localparam logic [7:0]  CONT_TAG = 8'h80;
    localparam logic [7:0]  LOW6_MSK = 8'h3F;

    localparam logic [2:0]  SEQ_NONE = 3'd0;
    localparam logic [2:0]  SEQ_LEN2 = 3'd2;
    localparam logic [2:0]  SEQ_LEN3 = 3'd3;
    localparam logic [2:0]  SEQ_LEN4 = 3'd4;

    // one accepted byte's worth of results: flush_cnt replacements, then the tail
    typedef struct packed {
        logic [1:0]  flush_cnt;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic        tail_rep;
        logic [2:0]  tail_used;
        logic        eot;
    } t_job;

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;
    } t_lead;

    function automatic t_lead fn_lead(input logic [7:0] b);
        t_lead r;
        r.len  = SEQ_NONE;
        r.bits = 5'd0;
        if (b[7:5] == 3'b110) begin
            r.len  = SEQ_LEN2;
            r.bits = b[4:0];
        end else if (b[7:4] == 4'b1110) begin
            r.len  = SEQ_LEN3;
            r.bits = {1'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            r.len  = SEQ_LEN4;
            r.bits = {2'b00, b[2:0]};
        end
        return r;
    endfunction

    function automatic logic [20:0] fn_min_cp(input logic [2:0] len);
        logic [20:0] m;
        unique case (len)
            SEQ_LEN2: m = MIN_CP2;
            SEQ_LEN3: m = MIN_CP3;
            default:  m = MIN_CP4;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/usd_ifs.sv
interface usd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface usd_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic [2:0]  bytes_used;
    logic        run_last;
    logic        text_done;

    modport source (output valid, output code_point, output replaced, output bytes_used,
                    output run_last, output text_done, input ready);
    modport sink   (input valid, input code_point, input replaced, input bytes_used,
                    input run_last, input text_done, output ready);
endinterface

FILE: rtl/usd_front.sv
module usd_front
    import usd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    usd_byte_if.sink    i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [2:0]  r_exp_len, n_exp_len;
    logic [1:0]  r_held, n_held;
    logic [20:0] r_partial, n_partial;

    logic        accept;
    logic [7:0]  b;
    logic        eot;
    logic [20:0] v;
    logic [2:0]  held_inc;
    logic        bad;
    t_lead       lead;
    t_job        job;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.text_byte;
    assign eot        = i_in.end_of_text;
    assign v          = {r_partial[14:0], b[5:0]};
    assign held_inc   = {1'b0, r_held} + 3'd1;
    assign lead       = fn_lead(b);
    assign bad        = (v < fn_min_cp(r_exp_len)) || (v > MAX_CP)
                        || (v >= SURR_LO && v <= SURR_HI);

    always_comb begin
        job           = '0;
        job.eot       = eot;
        job.tail_cp   = REPL_CP;
        job.tail_rep  = 1'b1;
        job.tail_used = 3'd1;
        n_exp_len     = r_exp_len;
        n_held        = r_held;
        n_partial     = r_partial;
        if (r_exp_len != SEQ_NONE && (b & CONT_MSK) == CONT_TAG) begin
            if (held_inc >= r_exp_len) begin
                job.has_tail  = 1'b1;
                job.tail_cp   = bad ? REPL_CP : v;
                job.tail_rep  = bad;
                job.tail_used = r_exp_len;
                n_exp_len     = SEQ_NONE;
                n_held        = 2'd0;
                n_partial     = '0;
            end else if (eot) begin
                job.flush_cnt = held_inc[1:0];
                n_exp_len     = SEQ_NONE;
                n_held        = 2'd0;
                n_partial     = '0;
            end else begin
                n_held    = held_inc[1:0];
                n_partial = v;
            end
        end else begin
            job.flush_cnt = (r_exp_len != SEQ_NONE) ? r_held : 2'd0;
            n_exp_len     = SEQ_NONE;
            n_held        = 2'd0;
            n_partial     = '0;
            if (!b[7]) begin
                job.has_tail = 1'b1;
                job.tail_cp  = {13'd0, b};
                job.tail_rep = 1'b0;
            end else if (lead.len != SEQ_NONE && !eot) begin
                n_exp_len = lead.len;
                n_held    = 2'd1;
                n_partial = {16'd0, lead.bits};
            end else begin
                job.has_tail = 1'b1;
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.has_tail || job.flush_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= SEQ_NONE;
            r_held    <= 2'd0;
            r_partial <= '0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_held    <= n_held;
            r_partial <= n_partial;
        end
    end

endmodule

FILE: rtl/usd_queue.sv
module usd_queue
    import usd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_IDX) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_IDX) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/usd_back.sv
module usd_back
    import usd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_job     i_job,
    output logic     o_pop,
    usd_cp_if.source o_out
);

    logic        r_busy;
    t_job        r_job;
    logic [1:0]  r_left;
    logic        r_ov;
    logic [20:0] r_cp;
    logic        r_rep;
    logic [2:0]  r_used;
    logic        r_last;
    logic        r_done;

    logic slot_free, emit, is_last;

    assign slot_free = !r_ov || o_out.ready;
    assign emit      = r_busy && slot_free;
    assign is_last   = (r_left == 2'd0) || (r_left == 2'd1 && !r_job.has_tail);
    assign o_pop     = i_q_valid && (!r_busy || (emit && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_left <= i_job.flush_cnt;
        end else if (emit && is_last) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_left != 2'd0) begin
                r_cp   <= REPL_CP;
                r_rep  <= 1'b1;
                r_used <= 3'd1;
            end else begin
                r_cp   <= r_job.tail_cp;
                r_rep  <= r_job.tail_rep;
                r_used <= r_job.tail_used;
            end
            r_last <= is_last;
            r_done <= is_last && r_job.eot;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.code_point = r_cp;
    assign o_out.replaced   = r_rep;
    assign o_out.bytes_used = r_used;
    assign o_out.run_last   = r_last;
    assign o_out.text_done  = r_done;

endmodule

FILE: rtl/utf8_stream_decoder.sv
// Channel  Dir  Fields                                               Transaction
// i_in     in   text_byte[7:0], end_of_text                          one text byte
// o_out    out  code_point[20:0], replaced, bytes_used[2:0],          one code point
//               run_last, text_done
//
// One byte accepted per cycle while the job queue has room; the front keeps
// the open-sequence state and turns each byte into a job of 0 to 4 results.
// The back delivers one result per cycle while o_out is ready, so a byte causing
// n results takes n transfers. Results are registered in the queue and the back.
// Synchronous active-low reset empties the queue and closes any open sequence.
// o_out stalls back up through the queue to i_in.ready only once it fills.
module utf8_stream_decoder
    import usd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    usd_byte_if.sink i_in,
    usd_cp_if.source o_out
);

    logic q_full, q_push, q_valid, q_pop;
    t_job push_job, pop_job;

    usd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (pop_job)
    );

    usd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (pop_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: dv/usd_decode_checker.sv
`timescale 1ns / 1ps
module usd_decode_checker
    import usd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    usd_byte_if         i_bytes,
    usd_cp_if           i_cps,
    output int unsigned o_fail_cnt,
    output int unsigned o_pending
);

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic [2:0]  bytes_used;
        logic        run_last;
        logic        text_done;
    } t_cp_rec;

    t_cp_rec     cp_expect_q[$];
    t_cp_rec     byte_cps_q[$];
    logic [2:0]  seq_len   = SEQ_NONE;
    logic [1:0]  seq_held  = '0;
    logic [20:0] seq_value = '0;
    int unsigned err_cnt   = 0;

    function automatic void queue_cp(input logic [20:0] cp, input logic rep,
                                     input logic [2:0] used);
        byte_cps_q.push_back(t_cp_rec'{code_point: cp, replaced: rep, bytes_used: used,
                                       run_last: 1'b0, text_done: 1'b0});
    endfunction

    function automatic void close_seq();
        seq_len   = SEQ_NONE;
        seq_held  = '0;
        seq_value = '0;
    endfunction

    // one replacement per byte held, then the sequence is gone
    function automatic void drop_open_seq();
        int i;
        for (i = 0; i < int'(seq_held); i++) begin
            queue_cp(REPL_CP, 1'b1, 3'd1);
        end
        close_seq();
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic eot);
        logic [2:0]  len;
        logic [20:0] bits;
        len  = SEQ_NONE;
        bits = '0;
        if (!b[7]) begin
            queue_cp({13'd0, b}, 1'b0, 3'd1);
        end else begin
            casez (b)
                8'b110?????: begin
                    len  = SEQ_LEN2;
                    bits = {16'd0, b[4:0]};
                end
                8'b1110????: begin
                    len  = SEQ_LEN3;
                    bits = {17'd0, b[3:0]};
                end
                8'b11110???: begin
                    len  = SEQ_LEN4;
                    bits = {18'd0, b[2:0]};
                end
                default: ;
            endcase
            if (len == SEQ_NONE || eot) begin
                queue_cp(REPL_CP, 1'b1, 3'd1);
            end else begin
                seq_len   = len;
                seq_held  = 2'd1;
                seq_value = bits;
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eot);
        logic [20:0] v;
        logic [2:0]  held_n;
        logic [20:0] floor_cp;
        logic        bad;
        t_cp_rec     last;
        byte_cps_q.delete();
        if (seq_len != SEQ_NONE) begin
            if (b[7:6] == 2'b10) begin
                v      = {seq_value[14:0], b[5:0]};
                held_n = {1'b0, seq_held} + 3'd1;
                if (held_n >= seq_len) begin
                    floor_cp = (seq_len == SEQ_LEN2) ? MIN_CP2 :
                               (seq_len == SEQ_LEN3) ? MIN_CP3 : MIN_CP4;
                    bad = (v < floor_cp) || (v > MAX_CP) || (v >= SURR_LO && v <= SURR_HI);
                    queue_cp(bad ? REPL_CP : v, bad, seq_len);
                    close_seq();
                end else begin
                    seq_held  = held_n[1:0];
                    seq_value = v;
                    if (eot) begin
                        drop_open_seq();
                    end
                end
            end else begin
                drop_open_seq();
                start_byte(b, eot);
            end
        end else begin
            start_byte(b, eot);
        end
        if (byte_cps_q.size() > 0) begin
            last = byte_cps_q.pop_back();
            last.run_last  = 1'b1;
            last.text_done = eot;
            byte_cps_q.push_back(last);
        end
        foreach (byte_cps_q[i]) begin
            cp_expect_q.push_back(byte_cps_q[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cp_rec got;
        t_cp_rec want;
        if (!i_rst_n) begin
            cp_expect_q.delete();
            close_seq();
        end else begin
            if (i_cps.valid && i_cps.ready) begin
                got = t_cp_rec'{code_point: i_cps.code_point, replaced: i_cps.replaced,
                                bytes_used: i_cps.bytes_used, run_last: i_cps.run_last,
                                text_done: i_cps.text_done};
                if (cp_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("ERROR: %0t unexpected code point cp=%h rep=%b used=%0d",
                                 $realtime, got.code_point, got.replaced, got.bytes_used);
                    end
                end else begin
                    want = cp_expect_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("ERROR: %0t code point mismatch", $realtime);
                            $display("  expected cp=%h rep=%b used=%0d last=%b done=%b",
                                     want.code_point, want.replaced, want.bytes_used,
                                     want.run_last, want.text_done);
                            $display("  actual   cp=%h rep=%b used=%0d last=%b done=%b",
                                     got.code_point, got.replaced, got.bytes_used,
                                     got.run_last, got.text_done);
                        end
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                predict_byte(i_bytes.text_byte, i_bytes.end_of_text);
            end
        end
        o_fail_cnt <= err_cnt;
        o_pending  <= cp_expect_q.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import usd_pkg::*;

    localparam int unsigned BYTE_TARGET  = 430;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // bit 8 marks end of text
    localparam logic [8:0] DIRECTED_BYTES [26] = '{
        9'h000, 9'h07F,                         // ASCII extremes
        9'h0C2, 9'h1A9,                         // 2-byte, text ends on it
        9'h0C0, 9'h080,                         // overlong
        9'h0ED, 9'h0A0, 9'h080,                 // surrogate
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // top of range
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // above top of range
        9'h080, 9'h0FF,                         // stray bytes
        9'h0F0, 9'h09F, 9'h098, 9'h0FF,         // broken 4-byte, then stray
        9'h0F0, 9'h19F,                         // cut by end of text
        9'h1C3                                  // lead byte at end of text
    };

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_cnt;
    int unsigned pending_cnt;
    int unsigned bytes_sent  = 0;
    int unsigned idle_cycles = 0;
    bit          in_idle     = 1'b1;
    bit          out_idle    = 1'b1;
    logic [7:0]  seq_q[$];

    usd_byte_if byte_if();
    usd_cp_if   cp_if();

    utf8_stream_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (cp_if)
    );

    usd_decode_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bytes    (byte_if),
        .i_cps      (cp_if),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_idle && $urandom_range(0, 7) == 0) begin
                cp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            cp_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL utf8_stream_decoder");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (in_idle && $urandom_range(0, 5) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.text_byte   <= b;
        byte_if.end_of_text <= eot;
        do @(posedge i_clk); while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic wait_all_cps();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        return {2'b10, bits};
    endfunction

    function automatic void push_lead(input int unsigned len);
        case (len)
            2:       seq_q.push_back({3'b110, 5'($urandom_range(0, 31))});
            3:       seq_q.push_back({4'b1110, 4'($urandom_range(0, 15))});
            default: seq_q.push_back({5'b11110, 3'($urandom_range(0, 7))});
        endcase
    endfunction

    function automatic void encode_cp(input logic [20:0] cp, input int unsigned len);
        case (len)
            1: seq_q.push_back({1'b0, cp[6:0]});
            2: begin
                seq_q.push_back({3'b110, cp[10:6]});
                seq_q.push_back(cont_byte(cp[5:0]));
            end
            3: begin
                seq_q.push_back({4'b1110, cp[15:12]});
                seq_q.push_back(cont_byte(cp[11:6]));
                seq_q.push_back(cont_byte(cp[5:0]));
            end
            default: begin
                seq_q.push_back({5'b11110, cp[20:18]});
                seq_q.push_back(cont_byte(cp[17:12]));
                seq_q.push_back(cont_byte(cp[11:6]));
                seq_q.push_back(cont_byte(cp[5:0]));
            end
        endcase
    endfunction

    // mostly well-formed characters; also random-valued, truncated and stray bytes
    task automatic send_random_chunk();
        int unsigned kind;
        int unsigned len;
        int unsigned n_cont;
        int unsigned i;
        logic [20:0] cp;
        logic        eot;
        seq_q.delete();
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if (kind < 55) begin
            case (len)
                1:       cp = 21'($urandom_range(0, 'h7F));
                2:       cp = 21'($urandom_range('h80, 'h7FF));
                3:       cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            if (cp >= SURR_LO && cp <= SURR_HI) begin
                cp = cp - 21'h800;
            end
            encode_cp(cp, len);
        end else if (kind < 85) begin
            len = $urandom_range(2, 4);
            push_lead(len);
            n_cont = (kind < 70) ? len - 1 : $urandom_range(0, len - 2);
            for (i = 0; i < n_cont; i++) begin
                seq_q.push_back(cont_byte(6'($urandom_range(0, 63))));
            end
        end else begin
            seq_q.push_back(8'($urandom_range(0, 255)));
        end
        eot = ($urandom_range(0, 9) == 0);
        foreach (seq_q[j]) begin
            send_byte(seq_q[j], eot && (j == seq_q.size() - 1));
        end
    endtask

    initial begin
        byte_if.valid       <= 1'b0;
        byte_if.text_byte   <= 8'h00;
        byte_if.end_of_text <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i]) begin
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        end
        wait_all_cps();

        while (bytes_sent < BYTE_TARGET) begin
            in_idle  = (bytes_sent < 310);
            out_idle = (bytes_sent < 150) || (bytes_sent >= 230 && bytes_sent < 310);
            send_random_chunk();
            if ($urandom_range(0, 39) == 0) begin
                wait_all_cps();
            end
        end

        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS utf8_stream_decoder");
        end else begin
            $display("FAIL utf8_stream_decoder");
        end
        $finish;
    end

endmodule
